FILE: hdl/iobps_pkg.sv
`timescale 1ns / 1ps
package iobps_pkg;

	localparam int PWM_SLOTS       = 8;
	localparam int PAYLOAD_WORDS   = 7;
	localparam int BEAT_W          = $clog2(PAYLOAD_WORDS);
	localparam int JOB_QUEUE_DEPTH = 2;

	localparam logic [7:0]  MAGIC          = 8'hBB;
	localparam logic [7:0]  CMD_PWM        = 8'hCB;
	localparam logic [7:0]  CMD_AIN        = 8'h3A;
	localparam logic [7:0]  CMD_DIN        = 8'h31;
	localparam logic [7:0]  CMD_AOUT       = 8'h41;
	localparam logic [7:0]  CMD_NONE       = 8'h00;
	localparam logic [7:0]  AOUT_PIN       = 8'd42;
	localparam logic [7:0]  PWM_ARG_A      = 8'd1;
	localparam logic [7:0]  RETRY_LIMIT_RST = 8'd10;
	localparam logic [12:0] PERIOD_RST     = 13'd4096;

	localparam logic [1:0]  CAP_NONE = 2'd0;

	typedef struct packed {
		logic        action;
		logic        pause;
		logic        write_ok;
		logic        resp_valid;
		logic [7:0]  resp_seq;
		logic [2:0]  pwm_slot;
		logic [12:0] pwm_duty;
	} in_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  command;
		logic [7:0]  arg_a;
		logic [7:0]  arg_b;
		logic [7:0]  arg_c;
		logic [7:0]  request_number;
		logic [7:0]  checksum;
		logic [2:0]  payload_slot;
		logic [12:0] payload_value;
		logic        last;
		logic        no_error;
		logic [1:0]  captured;
	} result_t;

	// One classified item: header, status and, for the PWM frame, a
	// snapshot of the seven payload words.
	typedef struct packed {
		logic                                send_valid;
		logic [7:0]                          command;
		logic [7:0]                          arg_a;
		logic [7:0]                          arg_b;
		logic [7:0]                          arg_c;
		logic [7:0]                          request_number;
		logic [7:0]                          checksum;
		logic [1:0]                          captured;
		logic                                no_error;
		logic                                burst;
		logic [PAYLOAD_WORDS-1:0][12:0]      vals;
	} job_t;

	// Q12 duty to 12-bit compare value, rounded: (4095*duty + 2048) >> 12.
	function automatic logic [12:0] scale_duty(input logic [12:0] duty);
		logic [24:0] prod;
		prod = 25'(duty) * 25'd4095 + 25'd2048;
		return {1'b0, prod[23:12]};
	endfunction

endpackage

FILE: hdl/io_board_poll_sequencer_unit.sv
`timescale 1ns / 1ps
// An accepted item is written into the job queue; its rows then reach the result ports through the output register.
// Throughput: one item accepted per cycle while the two-entry job queue has room;
// the result side emits one row per cycle while pop takes it, so a phase-0 poll tick
// expands to seven rows, a single-row item to one.
// Reset: arst_n clears all but mem_q and row_q; retry_limit to 10, PWM period slot to 4096.
module io_board_poll_sequencer_unit
	import iobps_pkg::*;
#(
	parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// item side
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	// result side
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration: retry_limit is the only register; the byte lanes of
	// paddr do not select anything, so every access lands on it.
	logic [7:0] retry_limit_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {24'b0, retry_limit_q} | {30'b0, paddr & 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_wr) begin
			retry_limit_q <= pwdata[7:0];
		end
	end

	// Front end: take the item beat, advance the poll sequence, and build
	// one job (header, status, payload snapshot) straight into the queue.
	logic take;
	job_t front_job;

	assign take = push && !full;

	iobps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (item),
		.retry_limit (retry_limit_q),
		.job         (front_job)
	);

	// Queue decouples classification from row expansion, so the front keeps
	// taking items, while the queue has room, as the back walks a seven-row PWM frame.
	job_t head_job;
	logic head_valid;
	logic head_pop;

	iobps_job_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take),
		.wr_job   (front_job),
		.full     (full),
		.rd_en    (head_pop),
		.rd_job   (head_job),
		.rd_valid (head_valid)
	);

	// Back end: expand each job into result beats through one output register.
	iobps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.job_pop   (head_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

`ifndef SYNTHESIS
	// A PWM frame row other than the period word never closes the item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.send_valid && result.command == CMD_PWM &&
		 result.payload_slot != 3'd6) |-> !result.last)
	else $error("PWM frame row closed the item early");

	// A status row carries no frame header.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.send_valid) |->
		(result.command == CMD_NONE && result.checksum == 8'd0 &&
		 result.payload_value == 13'd0))
	else $error("status row carries frame fields");

	// An accepted reply clears the retry count, so health must be good.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.captured != CAP_NONE) |-> result.no_error)
	else $error("captured reply reported unhealthy");

	// A result row that stalls keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
	else $error("stalled result row changed");
`endif

endmodule

FILE: hdl/iobps_job_queue.sv
`timescale 1ns / 1ps
module iobps_job_queue
	import iobps_pkg::*;
#(
	parameter int DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic rd_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/iobps_front.sv
`timescale 1ns / 1ps
module iobps_front
	import iobps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  in_item_t   item,
	input  logic [7:0] retry_limit,
	output job_t       job
);

	typedef enum logic [2:0] {
		PH_PWM  = 3'd0,
		PH_AIN  = 3'd1,
		PH_DIN  = 3'd2,
		PH_AOUT = 3'd3
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  retry_q, retry_n;
	logic [7:0]  req_q, req_n;
	logic [7:0]  lastcmd_q, lastcmd_n;
	logic        healthy_q, healthy_n;
	logic [12:0] store_q [PWM_SLOTS];

	logic [7:0]  cmd, arg_a, arg_b, arg_c, lc, poll_cmd;
	logic        send;
	logic [7:0]  sum;

	always_comb begin
		phase_n   = phase_q;
		retry_n   = retry_q;
		req_n     = req_q;
		lastcmd_n = lastcmd_q;
		healthy_n = healthy_q;
		cmd       = CMD_NONE;
		arg_a     = '0;
		arg_b     = '0;
		arg_c     = '0;
		send      = 1'b0;
		job       = '0;
		lc        = item.pause ? CMD_NONE : lastcmd_q;
		poll_cmd  = (phase_q == PH_AIN) ? CMD_AIN : CMD_DIN;

		if (!item.action) begin
			lastcmd_n = lc;
			unique case (phase_q)
				PH_PWM: begin
					send    = 1'b1;
					cmd     = CMD_PWM;
					arg_a   = PWM_ARG_A;
					phase_n = PH_AIN;
					if (item.write_ok) begin
						retry_n = '0;
					end
				end
				PH_AIN, PH_DIN: begin
					if (lc != poll_cmd) begin
						send = 1'b1;
						cmd  = poll_cmd;
					end else if (item.resp_valid && item.resp_seq == req_q) begin
						job.captured = phase_q[1:0];
						phase_n      = phase_t'(3'(phase_q + 1'b1));
						retry_n      = '0;
					end else begin
						retry_n = 8'(retry_q + 1'b1);
					end
				end
				PH_AOUT: begin
					send    = 1'b1;
					cmd     = CMD_AOUT;
					arg_a   = AOUT_PIN;
					arg_b   = store_q[6][11:4];
					arg_c   = {store_q[6][3:0], 4'b0000};
					phase_n = PH_PWM;
					if (item.write_ok) begin
						retry_n = '0;
					end
				end
				default: begin
					phase_n = PH_PWM;
				end
			endcase

			if (send) begin
				lastcmd_n = cmd;
				req_n     = 8'(req_q + 1'b1);
			end

			priority if (retry_n == '0) begin
				healthy_n = 1'b1;
			end else if (retry_n >= retry_limit) begin
				phase_n   = phase_t'(3'(phase_n + 1'b1));
				retry_n   = 8'd1;
				healthy_n = 1'b0;
			end
		end

		sum = 8'(MAGIC + cmd + arg_a + arg_b + arg_c + req_n);

		job.send_valid = send;
		job.no_error   = healthy_n;
		job.burst      = send && (cmd == CMD_PWM);
		if (send) begin
			job.command        = cmd;
			job.arg_a          = arg_a;
			job.arg_b          = arg_b;
			job.arg_c          = arg_c;
			job.request_number = req_n;
			job.checksum       = sum;
		end
		if (job.burst) begin
			for (int k = 0; k < PAYLOAD_WORDS - 1; k++) begin
				job.vals[k] = store_q[k];
			end
			job.vals[PAYLOAD_WORDS-1] = store_q[PWM_SLOTS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PWM;
			retry_q   <= '0;
			req_q     <= '0;
			lastcmd_q <= CMD_NONE;
			healthy_q <= 1'b1;
			for (int i = 0; i < PWM_SLOTS - 1; i++) begin
				store_q[i] <= '0;
			end
			store_q[PWM_SLOTS-1] <= PERIOD_RST;
		end else if (take) begin
			phase_q   <= phase_n;
			retry_q   <= retry_n;
			req_q     <= req_n;
			lastcmd_q <= lastcmd_n;
			healthy_q <= healthy_n;
			if (item.action) begin
				store_q[item.pwm_slot] <= scale_duty(item.pwm_duty);
			end
		end
	end

endmodule

FILE: hdl/iobps_back.sv
`timescale 1ns / 1ps
module iobps_back
	import iobps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  logic    job_valid,
	output logic    job_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic [BEAT_W-1:0] beat_q;
	logic              out_valid_q;
	result_t           row_q;
	result_t           row_d;
	logic              load;
	logic              final_beat;

	assign final_beat = !job.burst || (beat_q == BEAT_W'(PAYLOAD_WORDS - 1));
	assign load       = job_valid && (!out_valid_q || pop);
	assign job_pop    = load && final_beat;
	assign empty      = !out_valid_q;
	assign result     = row_q;

	always_comb begin
		row_d                = '0;
		row_d.send_valid     = job.send_valid;
		row_d.command        = job.command;
		row_d.arg_a          = job.arg_a;
		row_d.arg_b          = job.arg_b;
		row_d.arg_c          = job.arg_c;
		row_d.request_number = job.request_number;
		row_d.checksum       = job.checksum;
		row_d.captured       = job.captured;
		row_d.no_error       = job.no_error;
		row_d.last           = final_beat;
		if (job.burst) begin
			row_d.payload_slot  = 3'(beat_q);
			row_d.payload_value = job.vals[beat_q];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				beat_q <= final_beat ? '0 : BEAT_W'(beat_q + 1'b1);
			end
		end
	end

endmodule
